>>> hw/rtl/zcdp_pkg.sv
package zcdp_pkg;

  localparam int unsigned HdrBytes   = 46;
  localparam int unsigned HdrIdxW    = 6;
  localparam int unsigned PosInEntW  = 18;
  localparam logic [31:0] CdSignature = 32'h0201_4b50;
  localparam logic [31:0] EocdSignature = 32'h0605_4b50;
  localparam logic [31:0] Zip64Mark   = 32'hFFFF_FFFF;
  localparam logic [7:0]  SlashChar   = 8'h2F;
  localparam int unsigned EncryptBit  = 0;

  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    REG_ARCHIVE_SIZE = 2'd0,
    REG_DIR_OFFSET   = 2'd1,
    REG_ENTRY_LIMIT  = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_ZIP64  = 2'd2,
    ST_CRYPT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] archive_size;
    logic [31:0] directory_offset;
    logic [15:0] entry_limit;
    logic        rearm;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [31:0] header_offset;
    logic [15:0] name_length;
    logic        is_directory;
    logic [15:0] entry_index;
    logic        last;
  } rec_t;

endpackage

>>> hw/rtl/zip_central_directory_parser_top.sv
// ZIP central directory parser.
// Input channel (in_valid/in_ready/in_byte_in): directory bytes in archive
// order, the first at the configured directory offset. One byte per transfer.
// Result channel (out_*): one record per entry, sent on the entry's final
// byte, or one error record after which the parser halts.
// APB port: archive size at 0x0, directory offset at 0x4, entry limit at 0x8.
// Writing the directory offset restarts parsing at that edge; write registers
// only while idle. Throughput: one byte per cycle. Latency: a record is valid
// in the cycle after the transfer of the byte that completes it.
// A single output register holds the record; while it is full and out_ready
// is low, in_ready drops, and it rises again in the cycle the record leaves.
// After halt or once the entry limit is reached, bytes are taken and dropped.
// Reset (rst_n low, synchronous) clears the control and valid registers; an
// entry limit of zero means the parser starts out done until configured.
module zip_central_directory_parser_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zcdp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [15:0]                out_method,
  output logic [31:0]                out_crc_value,
  output logic [31:0]                out_packed_size,
  output logic [31:0]                out_plain_size,
  output logic [31:0]                out_header_offset,
  output logic [15:0]                out_name_length,
  output logic                       out_is_directory,
  output logic [15:0]                out_entry_index,
  output logic                       out_last
);
  import zcdp_pkg::*;

  cfg_t cfg;
  rec_t rec;
  rec_t rec_q;
  logic emit;
  logic can_take;

  zcdp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zcdp_entry_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (in_valid && can_take),
    .byte_in (in_byte_in),
    .emit    (emit),
    .rec     (rec)
  );

  zcdp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit),
    .rec_in   (rec),
    .can_take (can_take),
    .valid    (out_valid),
    .ready    (out_ready),
    .rec_out  (rec_q)
  );

  assign in_ready          = can_take;
  assign out_status        = rec_q.status;
  assign out_method        = rec_q.method;
  assign out_crc_value     = rec_q.crc_value;
  assign out_packed_size   = rec_q.packed_size;
  assign out_plain_size    = rec_q.plain_size;
  assign out_header_offset = rec_q.header_offset;
  assign out_name_length   = rec_q.name_length;
  assign out_is_directory  = rec_q.is_directory;
  assign out_entry_index   = rec_q.entry_index;
  assign out_last          = rec_q.last;

endmodule

>>> hw/rtl/zcdp_cfg_regs.sv
module zcdp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zcdp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output zcdp_pkg::cfg_t             cfg
);
  import zcdp_pkg::*;

  logic [31:0] archive_size_r;
  logic [31:0] dir_offset_r;
  logic [15:0] entry_limit_r;
  logic        rearm;
  logic        wr_en;
  reg_idx_t    idx;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign rearm  = wr_en && (idx == REG_DIR_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      archive_size_r <= '0;
      dir_offset_r   <= '0;
      entry_limit_r  <= '0;
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_ARCHIVE_SIZE: archive_size_r <= pwdata;
          REG_DIR_OFFSET:   dir_offset_r   <= pwdata;
          REG_ENTRY_LIMIT:  entry_limit_r  <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_ARCHIVE_SIZE: prdata = archive_size_r;
      REG_DIR_OFFSET:   prdata = dir_offset_r;
      REG_ENTRY_LIMIT:  prdata = {16'h0, entry_limit_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.archive_size     = archive_size_r;
  assign cfg.directory_offset = rearm ? pwdata : dir_offset_r;
  assign cfg.entry_limit      = entry_limit_r;
  assign cfg.rearm            = rearm;

endmodule

>>> hw/rtl/zcdp_entry_parser.sv
module zcdp_entry_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  zcdp_pkg::cfg_t  cfg,
  input  logic            step_en,
  input  logic [7:0]      byte_in,
  output logic            emit,
  output zcdp_pkg::rec_t  rec
);
  import zcdp_pkg::*;

  logic [31:0]          pos_r;
  logic [31:0]          start_r;
  logic [PosInEntW-1:0] k_r;
  logic [PosInEntW-1:0] total_r;
  logic [PosInEntW-1:0] total_nxt;
  logic [15:0]          done_cnt_r;
  logic                 halted_r;
  logic [7:0]           prev_r;
  logic [7:0]           prev_nxt;
  logic [7:0]           store_r [HdrBytes];

  logic                 active;
  logic                 step;
  logic                 in_hdr;
  logic                 at_hdr_end;
  logic                 past_hdr;
  logic [7:0]           b45;
  logic [31:0]          sig;
  logic [31:0]          packed_sz;
  logic [31:0]          plain_sz;
  logic [31:0]          hoff;
  logic [15:0]          name_len;
  logic [15:0]          extra_len;
  logic [15:0]          cmt_len;
  logic [32:0]          hdr_end;
  logic [32:0]          ent_end;
  logic                 err;
  status_t              err_code;
  logic                 name_end;
  logic                 entry_end;
  logic                 last_ok;

  assign active     = !halted_r && (done_cnt_r < cfg.entry_limit);
  assign step       = step_en && active;
  assign in_hdr     = k_r < PosInEntW'(HdrBytes);
  assign at_hdr_end = k_r == PosInEntW'(HdrBytes - 1);
  assign past_hdr   = k_r >= PosInEntW'(HdrBytes - 1);

  assign b45       = at_hdr_end ? byte_in : store_r[HdrBytes-1];
  assign sig       = {store_r[3], store_r[2], store_r[1], store_r[0]};
  assign packed_sz = {store_r[23], store_r[22], store_r[21], store_r[20]};
  assign plain_sz  = {store_r[27], store_r[26], store_r[25], store_r[24]};
  assign hoff      = {b45, store_r[44], store_r[43], store_r[42]};
  assign name_len  = {store_r[29], store_r[28]};
  assign extra_len = {store_r[31], store_r[30]};
  assign cmt_len   = {store_r[33], store_r[32]};

  assign total_nxt = PosInEntW'(HdrBytes) + PosInEntW'(name_len) + PosInEntW'(extra_len)
                     + PosInEntW'(cmt_len);

  assign hdr_end = {1'b0, start_r} + 33'(HdrBytes);
  assign ent_end = {1'b0, start_r} + 33'(total_r);

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    if (at_hdr_end) begin
      priority if (hdr_end > {1'b0, cfg.archive_size} || sig != CdSignature) begin
        err      = 1'b1;
        err_code = ST_BOUNDS;
      end else if (packed_sz == Zip64Mark || plain_sz == Zip64Mark || hoff == Zip64Mark) begin
        err      = 1'b1;
        err_code = ST_ZIP64;
      end else if (store_r[8][EncryptBit]) begin
        err      = 1'b1;
        err_code = ST_CRYPT;
      end else if (ent_end > {1'b0, cfg.archive_size}) begin
        err      = 1'b1;
        err_code = ST_BOUNDS;
      end else begin
        err      = 1'b0;
        err_code = ST_OK;
      end
    end
  end

  assign name_end  = (name_len != 16'h0) &&
                     (k_r == PosInEntW'(HdrBytes - 1) + PosInEntW'(name_len));
  assign prev_nxt  = name_end ? byte_in : prev_r;
  assign entry_end = ({1'b0, k_r} + 1'b1) >= {1'b0, total_r};
  assign last_ok   = ({1'b0, done_cnt_r} + 1'b1) >= {1'b0, cfg.entry_limit};

  assign emit = step && past_hdr && (err || entry_end);

  always_comb begin
    rec             = '0;
    rec.entry_index = done_cnt_r;
    if (err) begin
      rec.status = err_code;
      rec.last   = 1'b1;
    end else begin
      rec.status        = ST_OK;
      rec.method        = {store_r[11], store_r[10]};
      rec.crc_value     = {store_r[19], store_r[18], store_r[17], store_r[16]};
      rec.packed_size   = packed_sz;
      rec.plain_size    = plain_sz;
      rec.header_offset = hoff;
      rec.name_length   = name_len;
      rec.is_directory  = (name_len != 16'h0) && (prev_nxt == SlashChar);
      rec.last          = last_ok;
    end
  end

  // header bytes, entry length and start position: no reset, every field is written before it is used
  always_ff @(posedge clk) begin
    if (step && in_hdr) begin
      store_r[k_r[HdrIdxW-1:0]] <= byte_in;
    end
    total_r <= total_nxt;
    if (step && k_r == '0) begin
      start_r <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      k_r        <= '0;
      done_cnt_r <= '0;
      halted_r   <= 1'b0;
      prev_r     <= '0;
    end else if (cfg.rearm) begin
      pos_r      <= cfg.directory_offset;
      k_r        <= '0;
      done_cnt_r <= '0;
      halted_r   <= 1'b0;
      prev_r     <= '0;
    end else if (step) begin
      pos_r <= pos_r + 32'd1;
      priority if (!past_hdr) begin
        k_r <= k_r + 1'b1;
      end else if (err) begin
        halted_r <= 1'b1;
      end else if (!entry_end) begin
        k_r    <= k_r + 1'b1;
        prev_r <= prev_nxt;
      end else begin
        k_r        <= '0;
        prev_r     <= '0;
        done_cnt_r <= done_cnt_r + 16'd1;
      end
    end
  end

endmodule

>>> hw/rtl/zcdp_out_reg.sv
module zcdp_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  zcdp_pkg::rec_t  rec_in,
  output logic            can_take,
  output logic            valid,
  input  logic            ready,
  output zcdp_pkg::rec_t  rec_out
);
  import zcdp_pkg::*;

  logic valid_r;
  rec_t rec_r;

  assign can_take = !valid_r || ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      rec_r <= rec_in;
    end
  end

  assign valid   = valid_r;
  assign rec_out = rec_r;

endmodule
